/* rtl/stack_machine_word_executor_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the stack machine word executor
// Shared shorthand for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_WORD_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_WORD_EXECUTOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SMWE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define SMWE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/smwe_pkg.sv */
// ----------------------------------------------------------------------------
// Stack machine word executor package
// Field widths, operation codes, status codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package smwe_pkg;

  localparam int DATA_W     = 32;
  localparam int MODE_W     = 4;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int DEPTH_O_W  = 7;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 4'd0,
    MODE_ADD     = 4'd1,
    MODE_SUB     = 4'd2,
    MODE_MUL     = 4'd3,
    MODE_DIV     = 4'd4,
    MODE_DUP     = 4'd5,
    MODE_SWAP    = 4'd6,
    MODE_DROP    = 4'd7,
    MODE_PRINT   = 4'd8,
    MODE_NEWLINE = 4'd9
  } mode_e;

  // What a result emits.
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 2'd0,
    KIND_NUMBER  = 2'd1,
    KIND_NEWLINE = 2'd2
  } kind_e;

  // Completion status of one operation.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_TOP,
    S_RD_SECOND,
    S_WRITE,
    S_DIV,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/smwe_in_if.sv */
// ----------------------------------------------------------------------------
// Operation channel
// Valid/ready channel that carries one stack operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface smwe_in_if
  import smwe_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] literal;

  modport source (output valid, output mode, output literal, input ready);
  modport sink   (input valid, input mode, input literal, output ready);
endinterface

`default_nettype wire

/* rtl/smwe_out_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one operation result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface smwe_out_if
  import smwe_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        emit_kind;
  logic signed [DATA_W-1:0] emit_value;
  logic [STATUS_W-1:0]      status;
  logic [DEPTH_O_W-1:0]     depth_after;

  modport source (output valid, output emit_kind, output emit_value, output status,
                  output depth_after, input ready);
  modport sink   (input valid, input emit_kind, input emit_value, input status,
                  input depth_after, output ready);
endinterface

`default_nettype wire

/* rtl/smwe_ram.sv */
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module smwe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/smwe_div.sv */
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating
// toward zero with 32-bit wrap of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module smwe_div
  import smwe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   done_o,
  output logic      [DATA_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] mag_b_q;
  logic              neg_q;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W:0]   shifted;
  logic              fits;
  logic [DATA_W:0]   diff;

  // Operand magnitudes.
  assign mag_a = dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
  assign mag_b = divisor_i[DATA_W-1]  ? (DATA_W'(0) - divisor_i)  : divisor_i;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign fits    = shifted >= {1'b0, mag_b_q};
  assign diff    = shifted - {1'b0, mag_b_q};

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      quo_q   <= mag_a;
      mag_b_q <= mag_b;
      neg_q   <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

/* rtl/stack_machine_word_executor.sv */
// ----------------------------------------------------------------------------
// Stack machine word executor
// Runs one primitive stack operation per transaction on a data stack held in
// a synchronous RAM, and returns one result per operation.
// ----------------------------------------------------------------------------
// Usage:
// Operations enter on in_i (mode, literal) and results leave on out_o
// (emit_kind, emit_value, status, depth_after); each channel moves a
// transaction when valid and ready are both high. Every operation gives
// exactly one result. One operation is worked on at a time; in_i.ready is
// high while the controller is idle, also while a result waits in the output
// register. Each RAM access is a separate controller state on the one read
// and one write port: push, drop, newline, unknown codes and underflow or
// overflow go from decode straight to done; print, dup and a zero divisor
// also read the top entry; add, sub, mul and swap read the second entry as
// well and write back; divide runs the 32-step iterative divider before it
// writes. The controller returns to idle at the edge that loads the result.
// Reset empties the stack but not the RAM, whose unwritten entries go unused.
// If out_o stalls, the finished result stays in the output register and the
// controller holds its next result until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_word_executor
  import smwe_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  smwe_in_if.sink    in_i,
  smwe_out_if.source out_o
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  state_e state_q, state_d;

  logic [CNT_W-1:0]  count_q;
  mode_e             mode_q;
  logic [DATA_W-1:0] lit_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] a_q;
  kind_e             res_kind_q;
  logic [DATA_W-1:0] res_value_q;
  status_e           res_status_q;
  logic [CNT_W-1:0]  res_count_q;

  logic                 out_valid_q;
  logic [KIND_W-1:0]    out_kind_q;
  logic [DATA_W-1:0]    out_value_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [DEPTH_O_W-1:0] out_depth_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     second_addr;
  logic [AW-1:0]     push_addr;
  logic              is_full;
  logic              lt_one;
  logic              lt_two;
  status_e           dec_status;
  logic              two_operand;
  logic              arith;
  logic              div_by_zero;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] product;
  logic              in_take;
  logic              out_free;
  logic [CNT_W+DEPTH_O_W-1:0] depth_ext;

  // Stack data store.
  smwe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_smwe_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Iterative divider for the divide operation.
  smwe_div u_smwe_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ram_rdata),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Stack addresses and occupancy checks.
  assign cnt_m1      = count_q - 1'b1;
  assign cnt_m2      = count_q - CNT_W'(2);
  assign top_addr    = cnt_m1[AW-1:0];
  assign second_addr = cnt_m2[AW-1:0];
  assign push_addr   = count_q[AW-1:0];
  assign is_full     = count_q == FULL_CNT;
  assign lt_one      = count_q == '0;
  assign lt_two      = count_q < CNT_W'(2);

  assign arith       = (mode_q == MODE_ADD) || (mode_q == MODE_SUB) ||
                       (mode_q == MODE_MUL) || (mode_q == MODE_DIV);
  assign two_operand = arith || (mode_q == MODE_SWAP);
  assign div_by_zero = (mode_q == MODE_DIV) && (ram_rdata == '0);

  // Underflow and overflow decided from the count alone.
  always_comb begin
    dec_status = ST_OK;
    case (mode_q)
      MODE_PUSH:                      if (is_full) dec_status = ST_OVER;
      MODE_ADD, MODE_SUB, MODE_MUL,
      MODE_DIV, MODE_SWAP:            if (lt_two) dec_status = ST_UNDER;
      MODE_DUP: begin
        if (lt_one) begin
          dec_status = ST_UNDER;
        end else if (is_full) begin
          dec_status = ST_OVER;
        end
      end
      MODE_DROP, MODE_PRINT:          if (lt_one) dec_status = ST_UNDER;
      default:                        dec_status = ST_OK;
    endcase
  end

  // Arithmetic on the two registered operands.
  assign product = a_q * b_q;
  always_comb begin
    case (mode_q)
      MODE_ADD: alu_res = a_q + b_q;
      MODE_SUB: alu_res = a_q - b_q;
      MODE_MUL: alu_res = product;
      default:  alu_res = b_q;
    endcase
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign in_take  = in_i.valid && (state_q == S_IDLE);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (in_i.valid) state_d = S_DECODE;
      S_DECODE: begin
        if (dec_status != ST_OK) begin
          state_d = S_DONE;
        end else if (two_operand || (mode_q == MODE_PRINT) || (mode_q == MODE_DUP)) begin
          state_d = S_RD_TOP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RD_TOP: begin
        if ((mode_q == MODE_PRINT) || (mode_q == MODE_DUP) || div_by_zero) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RD_SECOND;
        end
      end
      S_RD_SECOND: state_d = (mode_q == MODE_DIV) ? S_DIV : S_WRITE;
      S_WRITE:     state_d = S_DONE;
      S_DIV:       if (div_done) state_d = S_DONE;
      S_DONE:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Memory and divider controls per state. The stack is only touched by
  // one operation at a time and each write lands before the next read is
  // issued, so no forwarding is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = second_addr;
    ram_wdata = alu_res;
    ram_re    = 1'b0;
    ram_raddr = top_addr;
    div_start = 1'b0;
    case (state_q)
      S_DECODE: begin
        ram_re = 1'b1;
        if ((mode_q == MODE_PUSH) && (dec_status == ST_OK)) begin
          ram_we    = 1'b1;
          ram_waddr = push_addr;
          ram_wdata = lit_q;
        end
      end
      S_RD_TOP: begin
        ram_re    = 1'b1;
        ram_raddr = second_addr;
        if (mode_q == MODE_DUP) begin
          ram_we    = 1'b1;
          ram_waddr = push_addr;
          ram_wdata = ram_rdata;
        end
      end
      S_RD_SECOND: begin
        if (mode_q == MODE_SWAP) begin
          ram_we    = 1'b1;
          ram_waddr = top_addr;
          ram_wdata = ram_rdata;
        end
        div_start = mode_q == MODE_DIV;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = second_addr;
        ram_wdata = (mode_q == MODE_SWAP) ? b_q : alu_res;
      end
      S_DIV: begin
        ram_we    = div_done;
        ram_waddr = second_addr;
        ram_wdata = div_quo;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign in_i.ready = state_q == S_IDLE;

  // Control state: controller, stack count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && out_free) begin
        count_q     <= res_count_q;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operation and result working registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= mode_e'(in_i.mode);
      lit_q  <= in_i.literal;
    end
    case (state_q)
      S_DECODE: begin
        res_kind_q   <= (mode_q == MODE_NEWLINE) ? KIND_NEWLINE : KIND_NONE;
        res_value_q  <= '0;
        res_status_q <= dec_status;
        res_count_q  <= count_q;
        if (dec_status == ST_OK) begin
          case (mode_q)
            MODE_PUSH:              res_count_q <= count_q + 1'b1;
            MODE_DUP:               res_count_q <= count_q + 1'b1;
            MODE_DROP, MODE_PRINT:  res_count_q <= cnt_m1;
            default:                res_count_q <= count_q;
          endcase
        end
      end
      S_RD_TOP: begin
        b_q <= ram_rdata;
        if (mode_q == MODE_PRINT) begin
          res_kind_q  <= KIND_NUMBER;
          res_value_q <= ram_rdata;
        end
        if (div_by_zero) begin
          res_status_q <= ST_DIVZ;
        end else if (arith) begin
          res_count_q <= cnt_m1;
        end
      end
      S_RD_SECOND: begin
        a_q <= ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // Output register payload.
  assign depth_ext = {{DEPTH_O_W{1'b0}}, res_count_q};
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      out_kind_q   <= res_kind_q;
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_depth_q  <= depth_ext[DEPTH_O_W-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.emit_kind   = out_kind_q;
  assign out_o.emit_value  = out_value_q;
  assign out_o.status      = out_status_q;
  assign out_o.depth_after = out_depth_q;

endmodule

`default_nettype wire

/* rtl/smwe_checker.sv */
// ----------------------------------------------------------------------------
// Stack machine word executor port checker
// Watches the top-level channels and checks result consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_machine_word_executor_macros.svh"

module smwe_checker
  import smwe_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic [KIND_W-1:0]        emit_kind_i,
  input wire logic signed [DATA_W-1:0] emit_value_i,
  input wire logic [STATUS_W-1:0]      status_i,
  input wire logic [DEPTH_O_W-1:0]     depth_after_i
);

  // Operations are handled one at a time: no accept right after an accept.
  `SMWE_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "operation accepted while the previous one is still in work")

  // A failed operation emits nothing.
  `SMWE_ASSERT(a_error_silent, clk_i, rst_ni, !(out_valid_i && (status_i != ST_OK)) || ((emit_kind_i == KIND_NONE) && (emit_value_i == '0)), "error result carries an emitted value")

  // Only a printed number carries a nonzero value.
  `SMWE_ASSERT(a_value_only_on_print, clk_i, rst_ni, !(out_valid_i && (emit_kind_i != KIND_NUMBER)) || (emit_value_i == '0), "nonzero value without a printed number")

  // The reported depth never exceeds the stack size (checked for stacks up to 127).
  `SMWE_ASSERT(a_depth_bound, clk_i, rst_ni, !out_valid_i || (STACK_DEPTH > 127) || (int'(depth_after_i) <= STACK_DEPTH), "reported depth beyond stack size")

  // A stalled result holds its payload.
  `SMWE_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(emit_kind_i) && $stable(emit_value_i) && $stable(status_i) && $stable(depth_after_i), "stalled result changed")

endmodule

bind stack_machine_word_executor smwe_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_smwe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .emit_kind_i   (out_o.emit_kind),
  .emit_value_i  (out_o.emit_value),
  .status_i      (out_o.status),
  .depth_after_i (out_o.depth_after)
);

`default_nettype wire

/* tb/stack_machine_word_executor_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine word executor testbench
// Drives stack operations through the operation channel and tracks a private
// copy of the data stack to predict every result. Directed tests cover the
// empty stack, the extremes of the arithmetic and division corner cases.
// Random tests then walk the stack depth, fill it to overflow and drain it,
// with random gaps on both channels and phases without any.
// ----------------------------------------------------------------------------

module stack_machine_word_executor_test;
  import smwe_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;
  localparam int MAX_GAP = 15;

  // Codes past the last defined operation; the block treats them as no-ops.
  localparam logic [MODE_W-1:0] FIRST_UNUSED_MODE = 4'hA;
  localparam logic [MODE_W-1:0] LAST_MODE_CODE = 4'hF;

  // One predicted result transaction.
  typedef struct {
    kind_e                kind;
    logic [DATA_W-1:0]    value;
    status_e              status;
    logic [DEPTH_O_W-1:0] depth;
  } op_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  smwe_in_if  in_if ();
  smwe_out_if out_if ();

  stack_machine_word_executor #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Private copy of the data stack, updated as operations are accepted.
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned       stack_fill = 0;

  op_result_t  pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap_max = MAX_GAP;
  int unsigned sink_gap_max = MAX_GAP;

  always #1 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Applies one operation to the private stack and returns its result.
  function automatic op_result_t apply_operation(input logic [MODE_W-1:0] mode,
                                                 input logic [DATA_W-1:0] literal);
    op_result_t        res;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] lhs_mag;
    logic [DATA_W-1:0] rhs_mag;
    logic [DATA_W-1:0] outcome;
    logic [DATA_W-1:0] swap_tmp;
    res.kind   = KIND_NONE;
    res.value  = '0;
    res.status = ST_OK;
    outcome    = '0;
    case (mode)
      MODE_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_mem[STACK_AW'(stack_fill)] = literal;
          stack_fill++;
        end
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
        if (stack_fill < 2) begin
          res.status = ST_UNDER;
        end else begin
          lhs = stack_mem[STACK_AW'(stack_fill-2)];
          rhs = stack_mem[STACK_AW'(stack_fill-1)];
          if (mode == MODE_DIV && rhs == '0) begin
            res.status = ST_DIVZ;
          end else begin
            case (mode)
              MODE_ADD: outcome = lhs + rhs;
              MODE_SUB: outcome = lhs - rhs;
              MODE_MUL: outcome = lhs * rhs;
              default: begin
                // Divide magnitudes, then restore the sign; the most negative
                // value over minus one wraps back to itself.
                lhs_mag = lhs[DATA_W-1] ? -lhs : lhs;
                rhs_mag = rhs[DATA_W-1] ? -rhs : rhs;
                outcome = lhs_mag / rhs_mag;
                if (lhs[DATA_W-1] != rhs[DATA_W-1]) outcome = -outcome;
              end
            endcase
            stack_mem[STACK_AW'(stack_fill-2)] = outcome;
            stack_fill--;
          end
        end
      end
      MODE_DUP: begin
        if (stack_fill < 1) begin
          res.status = ST_UNDER;
        end else if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_mem[STACK_AW'(stack_fill)] = stack_mem[STACK_AW'(stack_fill-1)];
          stack_fill++;
        end
      end
      MODE_SWAP: begin
        if (stack_fill < 2) begin
          res.status = ST_UNDER;
        end else begin
          swap_tmp                           = stack_mem[STACK_AW'(stack_fill-1)];
          stack_mem[STACK_AW'(stack_fill-1)] = stack_mem[STACK_AW'(stack_fill-2)];
          stack_mem[STACK_AW'(stack_fill-2)] = swap_tmp;
        end
      end
      MODE_DROP: begin
        if (stack_fill < 1) res.status = ST_UNDER;
        else stack_fill--;
      end
      MODE_PRINT: begin
        if (stack_fill < 1) begin
          res.status = ST_UNDER;
        end else begin
          res.kind  = KIND_NUMBER;
          res.value = stack_mem[STACK_AW'(stack_fill-1)];
          stack_fill--;
        end
      end
      MODE_NEWLINE: res.kind = KIND_NEWLINE;
      default: ;
    endcase
    res.depth = stack_fill[DEPTH_O_W-1:0];
    return res;
  endfunction

  // Sends one operation after a random gap and records its predicted result.
  task automatic send_operation(input logic [MODE_W-1:0] mode,
                                input logic [DATA_W-1:0] literal);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode;
    in_if.literal <= literal;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(apply_operation(mode, literal));
  endtask

  // Mostly stack operations, about a third pushes and a few unused codes.
  function automatic logic [MODE_W-1:0] pick_mode();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return MODE_W'($urandom_range(FIRST_UNUSED_MODE, LAST_MODE_CODE));
    if (roll < 35) return MODE_PUSH;
    return MODE_W'($urandom_range(MODE_ADD, MODE_NEWLINE));
  endfunction

  // Literals lean toward zero, small values and the extremes.
  function automatic logic [DATA_W-1:0] pick_literal();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      2: return {1'b1, {(DATA_W-1){1'b0}}};
      3: return {1'b0, {(DATA_W-1){1'b1}}};
      4: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Every operation other than push on an empty stack, plus unused codes.
  task automatic test_empty_stack();
    send_operation(MODE_ADD, $urandom);
    send_operation(MODE_SUB, $urandom);
    send_operation(MODE_MUL, $urandom);
    send_operation(MODE_DIV, $urandom);
    send_operation(MODE_DUP, $urandom);
    send_operation(MODE_SWAP, $urandom);
    send_operation(MODE_DROP, $urandom);
    send_operation(MODE_PRINT, $urandom);
    send_operation(MODE_NEWLINE, $urandom);
    send_operation(FIRST_UNUSED_MODE, $urandom);
    send_operation(LAST_MODE_CODE, $urandom);
  endtask

  // Two-operand operations with one entry, then a wrapping add.
  task automatic test_single_entry();
    send_operation(MODE_PUSH, 32'h7FFF_FFFF);
    send_operation(MODE_ADD, $urandom);
    send_operation(MODE_SWAP, $urandom);
    send_operation(MODE_DUP, $urandom);
    send_operation(MODE_ADD, $urandom);
    send_operation(MODE_PRINT, $urandom);
  endtask

  // The most negative value over minus one, then a zero divisor.
  task automatic test_division();
    send_operation(MODE_PUSH, 32'h8000_0000);
    send_operation(MODE_PUSH, 32'hFFFF_FFFF);
    send_operation(MODE_DIV, $urandom);
    send_operation(MODE_PUSH, '0);
    send_operation(MODE_DIV, $urandom);
    send_operation(MODE_DROP, $urandom);
    send_operation(MODE_PRINT, $urandom);
  endtask

  // Random operations that let the depth wander near the bottom.
  task automatic test_random_walk(input int unsigned count);
    repeat (count) send_operation(pick_mode(), pick_literal());
  endtask

  // Fill to the top, hit overflow, churn near full, then print it all out.
  task automatic test_fill_and_drain();
    while (stack_fill < STACK_DEPTH) send_operation(MODE_PUSH, pick_literal());
    send_operation(MODE_PUSH, pick_literal());
    send_operation(MODE_DUP, $urandom);
    repeat (40) send_operation(pick_mode(), pick_literal());
    while (stack_fill > 0) send_operation(MODE_PRINT, $urandom);
    send_operation(MODE_PRINT, $urandom);
  endtask

  // Compare each result transaction with the oldest prediction.
  initial begin : result_monitor
    int unsigned stall;
    op_result_t  want;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, sink_gap_max);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result %0d arrived with no operation outstanding", results_seen);
      end else begin
        want = pending_results.pop_front();
        if (out_if.emit_kind !== want.kind || out_if.emit_value !== want.value ||
            out_if.status !== want.status || out_if.depth_after !== want.depth) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $write("result %0d mismatch: expected kind %0d value %h ",
                   results_seen, want.kind, want.value);
            $write("status %0d depth %0d, ", want.status, want.depth);
            $display("got kind %0d value %h status %0d depth %0d",
                     out_if.emit_kind, out_if.emit_value, out_if.status,
                     out_if.depth_after);
          end
        end
      end
    end
  end

  // Reset, then the tests in turn, then wait for the last results.
  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.mode    <= MODE_PUSH;
    in_if.literal <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stack();
    test_single_entry();
    test_division();
    test_random_walk(1400);
    test_fill_and_drain();

    // Back-to-back traffic with no idling on either side.
    src_gap_max  = 0;
    sink_gap_max = 0;
    test_random_walk(300);

    // Stalls on the result side only.
    sink_gap_max = MAX_GAP;
    test_fill_and_drain();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
